[rtl/core/multiphase_pwm_timing_calc_macros.svh]
// Assertion macros for the multiphase PWM timing calculator.
// Used by the top level only; depends on nothing.
`ifndef MULTIPHASE_PWM_TIMING_CALC_MACROS_SVH
`define MULTIPHASE_PWM_TIMING_CALC_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define MPWM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define MPWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/core/mpwm_pkg.sv]
// Package for the multiphase PWM timing calculator: widths, constants,
// update kinds and the prescaler shift table. Depends on nothing.
package mpwm_pkg;
  localparam int CLK_W = 28;
  localparam int FREQ_W = 24;
  localparam int PCT_W = 14;
  localparam int PER_W = 16;
  localparam int CMP_W = 17;
  localparam int CODE_W = 3;
  localparam int KIND_W = 2;
  localparam int NCMP = 7;
  localparam int MUL_W = 31;
  localparam int RECIP_SHIFT = 44;
  localparam logic [MUL_W-1:0] RECIP_10000 = 31'd1759218605;
  localparam logic [PER_W-1:0] PERIOD_MAX = 16'd65535;
  localparam logic [PER_W-1:0] FAST_LIMIT = 16'd400;
  localparam logic [CMP_W-1:0] CMP_MAX = 17'd131071;
  localparam logic [CLK_W-1:0] CLOCK_RESET = 28'd80000000;
  localparam int IN_TDATA_W = 128;
  localparam int OUT_TDATA_W = 144;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 2'd0,
    KIND_BUFFERED = 2'd1,
    KIND_RESTART = 2'd2
  } kind_t;

  function automatic logic [3:0] presc_shift(input logic [CODE_W-1:0] code);
    logic [3:0] s;
    case (code)
      3'd7: s = 4'd8;
      default: s = {1'b0, code};
    endcase
    return s;
  endfunction
endpackage

[rtl/core/mpwm_cfg.sv]
// APB-style register port holding the timer clock frequency.
// Depends on mpwm_pkg.
module mpwm_cfg
  import mpwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [CLK_W-1:0] clock_hz
);
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_RESET;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      clock_hz <= pwdata[CLK_W-1:0];
    end
  end
  assign prdata = (paddr == 2'd0) ? {{(32-CLK_W){1'b0}}, clock_hz} : 32'd0;
endmodule

[rtl/core/mpwm_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on mpwm_pkg.
module mpwm_div
  import mpwm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CLK_W-1:0]  dividend,
  input  logic [FREQ_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [CLK_W-1:0]  quotient
);
  logic [FREQ_W:0] rem;
  logic [CLK_W-1:0] num;
  logic [FREQ_W-1:0] dsr;
  logic [4:0] count;
  logic [FREQ_W+1:0] trial;
  logic [FREQ_W+1:0] rem_sh;

  assign rem_sh = {rem, num[CLK_W-1]};
  assign trial = rem_sh - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 5'(CLK_W);
        rem <= '0;
        num <= dividend;
        dsr <= divisor;
      end else if (busy) begin
        num <= {num[CLK_W-2:0], 1'b0};
        if (!trial[FREQ_W+1]) begin
          rem <= trial[FREQ_W:0];
          quotient <= {quotient[CLK_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[FREQ_W:0];
          quotient <= {quotient[CLK_W-2:0], 1'b0};
        end
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[rtl/core/mpwm_mul.sv]
// Shared registered multiplier used for both scaling steps of each compare.
// Depends on mpwm_pkg.
module mpwm_mul
  import mpwm_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_W-1:0]   a,
  input  logic [MUL_W-1:0]   b,
  output logic [2*MUL_W-1:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

[rtl/core/multiphase_pwm_timing_calc.sv]
// Top level of the multiphase PWM timing calculator: sequencer, timing
// state and stream ports. Depends on mpwm_pkg, mpwm_cfg, mpwm_div, mpwm_mul
// and the assertion macro header.
//
// One input beat on s_tvalid/s_tready/s_tdata carries the requested
// frequency, the four channel widths and the phases of channels 2 to 4.
// One output beat on m_tvalid/m_tready/m_tdata follows with the prescaler
// code, the period, the seven compare values and the update kind. clock_hz
// is to be written over the APB-style port only while the block is idle;
// the block itself does not enforce this. An item passes from acceptance
// to the output beat through the shared divider that forms clock_hz/freq_hz
// (a start step, one step per quotient bit and a done step), the choice of
// the prescaler, seven compares that each use the shared multiplier twice,
// and the decision that loads the result. The next input beat is taken once
// the block is back in idle after that decision.
// s_tready is high only in the idle state; an unread result does not
// block the next input beat, but a finished result waits until the output
// register is free. Reset clears the stored timing, turns buffered mode
// off, drops m_tvalid and restores clock_hz to 80 MHz.
`include "multiphase_pwm_timing_calc_macros.svh"
module multiphase_pwm_timing_calc
  import mpwm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [1:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // freq_hz, ch1_width, ch2_phase, ch2_width, ch3_phase, ch3_width,
  // ch4_phase, ch4_width, zero padding
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // prescale_code, period_ticks, ch1_stop, ch2_start, ch2_stop, ch3_start,
  // ch3_stop, ch4_start, ch4_stop, update_kind, zero padding
  output logic [OUT_TDATA_W-1:0] m_tdata
);
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DIV    = 7'b0000010,
    S_PICK   = 7'b0000100,
    S_MA     = 7'b0001000,
    S_MB     = 7'b0010000,
    S_MC     = 7'b0100000,
    S_DECIDE = 7'b1000000
  } state_t;

  state_t state;
  logic [CLK_W-1:0] clock_hz;
  logic [FREQ_W-1:0] freq;
  logic [PCT_W-1:0] pct_in [0:6];
  logic div_start, div_busy, div_done;
  logic [CLK_W-1:0] quot;
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic [2:0] k;
  logic [CODE_W-1:0] code;
  logic [PER_W-1:0] period;
  logic [CMP_W-1:0] cmp [0:NCMP-1];
  logic [CODE_W-1:0] cur_prescale;
  logic [PER_W-1:0] cur_period;
  logic [CMP_W-1:0] cur_cmp [0:NCMP-1];
  logic start1_set;
  logic buffered_mode;
  kind_t kind;

  logic [CODE_W-1:0] pick_code;
  logic [PER_W-1:0] pick_period;
  logic [PCT_W:0] pct_sel;
  logic [CMP_W+1:0] cmp_raw;
  logic changed, fast, restart;
  logic out_free;

  mpwm_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .clock_hz(clock_hz)
  );

  mpwm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(clock_hz),
    .divisor(freq), .busy(div_busy), .done(div_done), .quotient(quot)
  );

  mpwm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  assign div_start = (state == S_DIV) && !div_busy && !div_done;
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    logic [CLK_W-1:0] m;
    logic in_range;
    m = quot >> presc_shift(cur_prescale);
    in_range = (m <= CLK_W'(PERIOD_MAX)) && (m >= CLK_W'(FAST_LIMIT));
    pick_code = cur_prescale;
    if (!in_range) begin
      pick_code = 3'd7;
      for (int c = 6; c >= 0; c--) begin
        if ((quot >> presc_shift(3'(c))) < CLK_W'(PERIOD_MAX)) begin
          pick_code = 3'(c);
        end
      end
    end
    m = quot >> presc_shift(pick_code);
    pick_period = (m > CLK_W'(PERIOD_MAX)) ? PERIOD_MAX : m[PER_W-1:0];
  end

  always_comb begin
    case (k)
      3'd0: pct_sel = {1'b0, pct_in[0]};
      3'd1: pct_sel = {1'b0, pct_in[1]};
      3'd2: pct_sel = {1'b0, pct_in[1]} + {1'b0, pct_in[2]};
      3'd3: pct_sel = {1'b0, pct_in[3]};
      3'd4: pct_sel = {1'b0, pct_in[3]} + {1'b0, pct_in[4]};
      3'd5: pct_sel = {1'b0, pct_in[5]};
      default: pct_sel = {1'b0, pct_in[5]} + {1'b0, pct_in[6]};
    endcase
  end

  always_comb begin
    if (state == S_MB) begin
      mul_a = mul_p[MUL_W-1:0];
      mul_b = RECIP_10000;
    end else begin
      mul_a = {{(MUL_W-PER_W){1'b0}}, period};
      mul_b = {{(MUL_W-PCT_W-1){1'b0}}, pct_sel};
    end
  end

  assign cmp_raw = {1'b0, mul_p[2*MUL_W-1:RECIP_SHIFT]} + 19'd1;

  always_comb begin
    changed = (code != cur_prescale) || (period != cur_period) || !start1_set;
    for (int i = 0; i < NCMP; i++) begin
      if (cmp[i] != cur_cmp[i]) begin
        changed = 1'b1;
      end
    end
    fast = (code == 3'd0) && (period < FAST_LIMIT);
    restart = (code != cur_prescale) || fast || !buffered_mode;
    kind = KIND_NONE;
    if (changed) begin
      kind = restart ? KIND_RESTART : KIND_BUFFERED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      cur_prescale <= '0;
      cur_period <= '0;
      start1_set <= 1'b0;
      buffered_mode <= 1'b0;
      for (int i = 0; i < NCMP; i++) begin
        cur_cmp[i] <= '0;
      end
    end else begin
      if ((state == S_DECIDE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            freq <= (s_tdata[FREQ_W-1:0] == '0) ? FREQ_W'(1) : s_tdata[FREQ_W-1:0];
            for (int i = 0; i < 7; i++) begin
              pct_in[i] <= s_tdata[FREQ_W + PCT_W*i +: PCT_W];
            end
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          code <= pick_code;
          period <= pick_period;
          k <= '0;
          state <= S_MA;
        end
        S_MA: begin
          state <= S_MB;
        end
        S_MB: begin
          state <= S_MC;
        end
        S_MC: begin
          cmp[k] <= (cmp_raw > {2'b00, CMP_MAX}) ? CMP_MAX : cmp_raw[CMP_W-1:0];
          if (k == 3'(NCMP - 1)) begin
            state <= S_DECIDE;
          end else begin
            k <= k + 3'd1;
            state <= S_MA;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            if (changed) begin
              if (restart) begin
                buffered_mode <= !fast;
              end
              cur_prescale <= code;
              cur_period <= period;
              start1_set <= 1'b1;
              for (int i = 0; i < NCMP; i++) begin
                cur_cmp[i] <= cmp[i];
              end
            end
            m_tdata <= {4'd0, kind, cmp[6], cmp[5], cmp[4], cmp[3], cmp[2], cmp[1],
                        cmp[0], period, code};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MPWM_ASSERT_NOW(a_kind_legal, clk, rst, m_tvalid, m_tdata[139:138] != 2'd3)
  `MPWM_ASSERT_NOW(a_ready_div_idle, clk, rst, s_tready, !div_busy)
  `MPWM_ASSERT_NEXT(a_fast_unbuffered, clk, rst,
                    (state == S_DECIDE) && out_free && changed && fast, !buffered_mode)
endmodule
